[sv/rmth_pkg.sv]
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types for the running median block: controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rmth_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP_START,
        ST_POP_LOAD,
        ST_POP_RD,
        ST_POP_CMP,
        ST_PUSH_START,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_TOP_RD,
        ST_MEDIAN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PLAN_PUSH_X,
        PLAN_MOVE,
        PLAN_DONE
    } plan_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic pop_start;
        logic pop_load;
        logic pop_rd;
        logic pop_cmp;
        logic push_start;
        logic push_rd;
        logic push_cmp;
        logic top_rd;
        logic median;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic       move;
        logic       more_push;
        logic       push_done;
        logic       pop_done;
        logic       out_busy;
    } status_t;

endpackage

[sv/running_median_two_heaps_top.sv]
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median of a signed stream using a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// channel | signals                                   | word
// in      | in_valid in_stall sample restart          | one sample
// out     | out_valid out_stall median_twice          | one result
//         | samples_held overflow                     |
// One word at a time.
// A top may move across heaps before the push; a word on a full store is dropped.
// Reset clears counts and median; heap contents need no clearing.
// Output is registered; a stalled result holds while the next word is worked.
module running_median_two_heaps_top #(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        sample,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [32:0] median_twice,
    output logic [10:0]        samples_held,
    output logic               overflow
);

    rmth_pkg::cmd_t    cmd;
    rmth_pkg::status_t status;

    rmth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rmth_datapath #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .restart      (restart),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .median_twice (median_twice),
        .samples_held (samples_held),
        .overflow     (overflow)
    );

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (samples_held <= 11'(CAPACITY)))
        else $error("samples_held beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (samples_held == 11'(CAPACITY)))
        else $error("overflow without full store");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.out_load, cmd.median}) <= 1)
        else $error("conflicting commands");

endmodule

[sv/rmth_datapath.sv]
// ----------------------------------------------------------------------------
// rmth_datapath
// Two heap memories, counters, sift logic and the output register.
// ----------------------------------------------------------------------------
module rmth_datapath #(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmth_pkg::cmd_t        cmd,
    output rmth_pkg::status_t     status,
    input  logic [31:0]           sample,
    input  logic                  restart,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic signed [32:0]    median_twice,
    output logic [10:0]           samples_held,
    output logic                  overflow
);

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = $clog2(CAPACITY + 1);
    localparam int SB    = SAMPLE_BITS;

    logic signed [SB-1:0] lo_mem [DEPTH];
    logic signed [SB-1:0] hi_mem [DEPTH];

    logic [CW-1:0]        lo_cnt_reg, hi_cnt_reg;
    logic signed [SB:0]   med_reg;
    logic signed [SB-1:0] x_reg;
    logic                 ovf_reg;
    rmth_pkg::plan_t      plan_reg;
    logic                 side_reg;    // 1 = upper heap for current op
    logic                 xside_reg;
    logic signed [SB-1:0] val_reg;     // value being sifted
    logic signed [SB-1:0] moved_reg;   // top taken off by a move
    logic [AW-1:0]        idx_reg;
    logic [CW-1:0]        n_reg;
    logic signed [SB-1:0] rd_a_reg, rd_b_reg;
    logic signed [SB-1:0] lo_top_reg, hi_top_reg;

    logic                 out_valid_reg;
    logic signed [32:0]   med_out_reg;
    logic [10:0]          held_out_reg;
    logic                 ovf_out_reg;

    logic                 wr_en;
    logic signed [SB-1:0] wr_data;
    logic [AW-1:0]        ra, rb;
    logic [AW-1:0]        par;
    logic [AW-1:0]        last_addr;

    logic signed [SB-1:0] x_in;
    logic [TW-1:0]        total;
    logic                 full;
    logic signed [SB:0]   x2;
    logic                 move_now, xside_now;
    logic [AW+1:0]        lchild, rchild;
    logic                 l_ok, r_ok, take_l, pick_r, move_up;

    function automatic logic above_f(input logic signed [SB-1:0] a,
                                     input logic signed [SB-1:0] b,
                                     input logic up);
        above_f = up ? (a < b) : (a > b);
    endfunction

    assign x_in      = sample[SB-1:0];
    assign total     = TW'(lo_cnt_reg) + TW'(hi_cnt_reg);
    assign full      = (total >= TW'(CAPACITY));
    assign x2        = {x_reg, 1'b0};
    assign par       = (idx_reg - 1'b1) >> 1;
    assign last_addr = side_reg ? AW'(hi_cnt_reg - 1'b1) : AW'(lo_cnt_reg - 1'b1);
    assign lchild    = {1'b0, idx_reg, 1'b1};
    assign rchild    = {({1'b0, idx_reg} + 1'b1), 1'b0};
    assign l_ok      = lchild < (AW+2)'(n_reg);
    assign r_ok      = rchild < (AW+2)'(n_reg);
    assign take_l    = l_ok && above_f(rd_a_reg, val_reg, side_reg);
    assign pick_r    = r_ok && (take_l ? above_f(rd_b_reg, rd_a_reg, side_reg)
                                       : above_f(rd_b_reg, val_reg, side_reg));
    assign move_up   = (idx_reg != '0) && above_f(val_reg, rd_a_reg, side_reg);

    // placement of the new sample
    always_comb
    begin
        move_now  = 1'b0;
        xside_now = 1'b0;
        if (total != '0)
        begin
            if (lo_cnt_reg == hi_cnt_reg)
                xside_now = (x2 >= med_reg);
            else if (lo_cnt_reg > hi_cnt_reg)
            begin
                move_now  = (x2 < med_reg);
                xside_now = !(x2 < med_reg);
            end
            else
            begin
                move_now  = (x2 > med_reg);
                xside_now = (x2 > med_reg);
            end
        end
    end

    // status
    assign status.full      = full;
    assign status.move      = move_now;
    assign status.more_push = (plan_reg != rmth_pkg::PLAN_DONE);
    assign status.push_done = !move_up;
    assign status.pop_done  = !pick_r && !take_l;
    assign status.out_busy  = out_valid_reg && out_stall;

    // read addresses
    always_comb
    begin
        ra = par;
        rb = last_addr;
        if (cmd.pop_start)
            ra = '0;
        if (cmd.pop_rd)
        begin
            ra = AW'(lchild);
            rb = AW'(rchild);
        end
        if (cmd.top_rd)
        begin
            ra = '0;
            rb = '0;
        end
    end

    // write port
    always_comb
    begin
        wr_en   = cmd.push_cmp || cmd.pop_cmp;
        wr_data = val_reg;
        if (cmd.push_cmp && move_up)
            wr_data = rd_a_reg;
        if (cmd.pop_cmp)
        begin
            if (pick_r)
                wr_data = rd_b_reg;
            else if (take_l)
                wr_data = rd_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_rd || cmd.pop_start || cmd.pop_rd)
            rd_a_reg <= side_reg ? hi_mem[ra] : lo_mem[ra];
        if (cmd.pop_start || cmd.pop_rd)
            rd_b_reg <= side_reg ? hi_mem[rb] : lo_mem[rb];
        if (cmd.top_rd)
        begin
            lo_top_reg <= lo_mem[ra];
            hi_top_reg <= hi_mem[rb];
        end
        if (wr_en)
        begin
            if (side_reg)
                hi_mem[idx_reg] <= wr_data;
            else
                lo_mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= x_in;
        if (cmd.pop_load)
        begin
            moved_reg <= rd_a_reg;
            val_reg   <= rd_b_reg;
        end
        if (cmd.push_start)
            val_reg <= (plan_reg == rmth_pkg::PLAN_MOVE) ? moved_reg : x_reg;
        if (cmd.out_load)
        begin
            med_out_reg  <= 33'(med_reg);
            held_out_reg <= 11'(total);
            ovf_out_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_cnt_reg    <= '0;
            hi_cnt_reg    <= '0;
            med_reg       <= '0;
            plan_reg      <= rmth_pkg::PLAN_DONE;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            side_reg      <= 1'b0;
            xside_reg     <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            if (cmd.load && restart)
            begin
                lo_cnt_reg <= '0;
                hi_cnt_reg <= '0;
                med_reg    <= '0;
            end
            if (cmd.decide)
            begin
                ovf_reg   <= full;
                side_reg  <= xside_now;
                xside_reg <= xside_now;
                plan_reg  <= move_now ? rmth_pkg::PLAN_MOVE : rmth_pkg::PLAN_PUSH_X;
            end
            if (cmd.pop_start)
            begin
                if (side_reg)
                begin
                    n_reg      <= hi_cnt_reg - 1'b1;
                    hi_cnt_reg <= hi_cnt_reg - 1'b1;
                end
                else
                begin
                    n_reg      <= lo_cnt_reg - 1'b1;
                    lo_cnt_reg <= lo_cnt_reg - 1'b1;
                end
            end
            if (cmd.pop_load)
                idx_reg <= '0;
            if (cmd.pop_cmp)
            begin
                if (pick_r)
                    idx_reg <= AW'(rchild);
                else if (take_l)
                    idx_reg <= AW'(lchild);
            end
            if (cmd.push_start)
            begin
                if (plan_reg == rmth_pkg::PLAN_MOVE)
                begin
                    side_reg <= !xside_reg;
                    plan_reg <= rmth_pkg::PLAN_PUSH_X;
                    if (xside_reg)
                    begin
                        idx_reg    <= AW'(lo_cnt_reg);
                        lo_cnt_reg <= lo_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg    <= AW'(hi_cnt_reg);
                        hi_cnt_reg <= hi_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    side_reg <= xside_reg;
                    plan_reg <= rmth_pkg::PLAN_DONE;
                    if (xside_reg)
                    begin
                        idx_reg    <= AW'(hi_cnt_reg);
                        hi_cnt_reg <= hi_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg    <= AW'(lo_cnt_reg);
                        lo_cnt_reg <= lo_cnt_reg + 1'b1;
                    end
                end
            end
            if (cmd.push_cmp && move_up)
                idx_reg <= par;
            if (cmd.median && !ovf_reg)
            begin
                if (lo_cnt_reg > hi_cnt_reg)
                    med_reg <= {lo_top_reg, 1'b0};
                else if (hi_cnt_reg > lo_cnt_reg)
                    med_reg <= {hi_top_reg, 1'b0};
                else
                    med_reg <= {lo_top_reg[SB-1], lo_top_reg}
                             + {hi_top_reg[SB-1], hi_top_reg};
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = med_out_reg;
    assign samples_held = held_out_reg;
    assign overflow     = ovf_out_reg;

endmodule

[sv/rmth_ctrl.sv]
// ----------------------------------------------------------------------------
// rmth_ctrl
// Sequencer: decide, optional move (pop then push), push, read tops, output; a full store goes straight to output.
// ----------------------------------------------------------------------------
module rmth_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rmth_pkg::status_t   status,
    output rmth_pkg::cmd_t      cmd
);

    rmth_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rmth_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            rmth_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rmth_pkg::ST_DECIDE;
                end
            end
            rmth_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.full)
                    state_next = rmth_pkg::ST_OUT;
                else if (status.move)
                    state_next = rmth_pkg::ST_POP_START;
                else
                    state_next = rmth_pkg::ST_PUSH_START;
            end
            rmth_pkg::ST_POP_START:
            begin
                cmd.pop_start = 1'b1;
                state_next    = rmth_pkg::ST_POP_LOAD;
            end
            rmth_pkg::ST_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = rmth_pkg::ST_POP_RD;
            end
            rmth_pkg::ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = rmth_pkg::ST_POP_CMP;
            end
            rmth_pkg::ST_POP_CMP:
            begin
                cmd.pop_cmp = 1'b1;
                if (status.pop_done)
                    state_next = rmth_pkg::ST_PUSH_START;
                else
                    state_next = rmth_pkg::ST_POP_RD;
            end
            rmth_pkg::ST_PUSH_START:
            begin
                cmd.push_start = 1'b1;
                state_next     = rmth_pkg::ST_PUSH_RD;
            end
            rmth_pkg::ST_PUSH_RD:
            begin
                cmd.push_rd = 1'b1;
                state_next  = rmth_pkg::ST_PUSH_CMP;
            end
            rmth_pkg::ST_PUSH_CMP:
            begin
                cmd.push_cmp = 1'b1;
                if (!status.push_done)
                    state_next = rmth_pkg::ST_PUSH_RD;
                else if (status.more_push)
                    state_next = rmth_pkg::ST_PUSH_START;
                else
                    state_next = rmth_pkg::ST_TOP_RD;
            end
            rmth_pkg::ST_TOP_RD:
            begin
                cmd.top_rd = 1'b1;
                state_next = rmth_pkg::ST_MEDIAN;
            end
            rmth_pkg::ST_MEDIAN:
            begin
                cmd.median = 1'b1;
                state_next = rmth_pkg::ST_OUT;
            end
            rmth_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rmth_pkg::ST_IDLE;
                end
            end
            default:
                state_next = rmth_pkg::ST_IDLE;
        endcase
    end

endmodule

[verif/running_median_two_heaps_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_top_tb
// Drives signed samples with random restarts into the running median block and
// compares each result word with a two-heap median predictor kept in the bench.
// Covers extremes, ties, the full store with dropped samples, restart on a full
// store, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top_tb;

    localparam int CAPACITY   = 1024;
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int LIMIT      = 3000000;

    typedef struct {
        logic [31:0] sample;
        logic        restart;
    } sample_word_t;

    typedef struct {
        logic signed [32:0] median_twice;
        logic [10:0]        samples_held;
        logic               overflow;
    } median_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        sample;
    logic               restart;
    logic               out_valid;
    logic               out_stall;
    logic signed [32:0] median_twice;
    logic [10:0]        samples_held;
    logic               overflow;

    sample_word_t pending_samples[$];
    median_word_t expected_medians[$];

    longint lo_heap[HALF_DEPTH];
    longint hi_heap[HALF_DEPTH];
    int     lo_count;
    int     hi_count;
    longint median_x2;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit  hold_request;
    bit  hold_started;
    int  hold_cycles;
    int  fail_count;
    int  cycle_count;

    running_median_two_heaps_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_twice (median_twice),
        .samples_held (samples_held),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit ranks_higher(longint a, longint b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_max, longint v);
        int     i;
        int     p;
        longint t;
        if (is_max)
        begin
            i = lo_count;
            lo_heap[i] = v;
            lo_count++;
        end
        else
        begin
            i = hi_count;
            hi_heap[i] = v;
            hi_count++;
        end
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (is_max)
            begin
                if (!ranks_higher(lo_heap[i], lo_heap[p], 1)) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
            end
            else
            begin
                if (!ranks_higher(hi_heap[i], hi_heap[p], 0)) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
            end
            i = p;
        end
    endtask

    task automatic heap_extract(bit is_max, output longint top);
        int     n;
        int     i;
        int     l;
        int     best;
        longint t;
        i = 0;
        if (is_max)
        begin
            top = lo_heap[0];
            lo_count--;
            n = lo_count;
            lo_heap[0] = lo_heap[n];
        end
        else
        begin
            top = hi_heap[0];
            hi_count--;
            n = hi_count;
            hi_heap[0] = hi_heap[n];
        end
        forever
        begin
            l = 2 * i + 1;
            best = i;
            if (is_max)
            begin
                if (l < n && lo_heap[l] > lo_heap[best]) best = l;
                if (l + 1 < n && lo_heap[l + 1] > lo_heap[best]) best = l + 1;
                if (best == i) break;
                t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
            end
            else
            begin
                if (l < n && hi_heap[l] < hi_heap[best]) best = l;
                if (l + 1 < n && hi_heap[l + 1] < hi_heap[best]) best = l + 1;
                if (best == i) break;
                t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
            end
            i = best;
        end
    endtask

    task automatic predict_median(sample_word_t w);
        longint       x;
        longint       moved;
        median_word_t r;
        x = longint'($signed(w.sample));
        r.overflow = 1'b0;
        if (w.restart)
        begin
            lo_count = 0;
            hi_count = 0;
            median_x2 = 0;
        end
        if (lo_count + hi_count >= CAPACITY)
            r.overflow = 1'b1;
        else if (lo_count + hi_count == 0)
        begin
            heap_insert(1, x);
            median_x2 = 2 * x;
        end
        else if (lo_count == hi_count)
        begin
            if (2 * x >= median_x2)
            begin
                heap_insert(0, x);
                median_x2 = 2 * hi_heap[0];
            end
            else
            begin
                heap_insert(1, x);
                median_x2 = 2 * lo_heap[0];
            end
        end
        else
        begin
            if (lo_count > hi_count)
            begin
                if (2 * x < median_x2)
                begin
                    heap_extract(1, moved);
                    heap_insert(0, moved);
                    heap_insert(1, x);
                end
                else
                    heap_insert(0, x);
            end
            else
            begin
                if (2 * x > median_x2)
                begin
                    heap_extract(0, moved);
                    heap_insert(1, moved);
                    heap_insert(0, x);
                end
                else
                    heap_insert(1, x);
            end
            median_x2 = lo_heap[0] + hi_heap[0];
        end
        r.median_twice = median_x2[32:0];
        r.samples_held = 11'(lo_count + hi_count);
        expected_medians.push_back(r);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_sample(logic [31:0] s, logic r);
        sample_word_t w;
        w.sample = s;
        w.restart = r;
        pending_samples.push_back(w);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            restart  <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_median('{sample, restart});
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                sample   <= pending_samples[0].sample;
                restart  <= pending_samples[0].restart;
                void'(pending_samples.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_medians.size() == 0)
                begin
                    $error("unexpected result word, median_twice %0d", median_twice);
                    fail_count++;
                end
                else
                begin
                    if (median_twice !== expected_medians[0].median_twice)
                    begin
                        $error("median_twice expected %0d actual %0d",
                               expected_medians[0].median_twice, median_twice);
                        fail_count++;
                    end
                    if (samples_held !== expected_medians[0].samples_held)
                    begin
                        $error("samples_held expected %0d actual %0d",
                               expected_medians[0].samples_held, samples_held);
                        fail_count++;
                    end
                    if (overflow !== expected_medians[0].overflow)
                    begin
                        $error("overflow expected %0d actual %0d",
                               expected_medians[0].overflow, overflow);
                        fail_count++;
                    end
                    void'(expected_medians.pop_front());
                end
            end
            out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
        end
        else
            out_stall <= 1'b0;
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_cycles  <= 4000;
            hold_off     <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            hold_off    <= 1'b1;
        end
        else
            hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("running_median_two_heaps_top_tb: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || expected_medians.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first sample, extremes, ties, halves, restart
        queue_sample(32'h7fff_ffff, 1'b0);
        queue_sample(32'h7fff_fffe, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h7fff_ffff, 1'b0);
        queue_sample(32'd5, 1'b1);
        queue_sample(32'd5, 1'b0);
        queue_sample(32'd5, 1'b0);
        queue_sample(32'd6, 1'b0);
        queue_sample(32'hffff_ffff, 1'b0);
        queue_sample(32'd0, 1'b0);
        queue_sample(32'd3, 1'b0);
        queue_sample(32'd9, 1'b0);
        queue_sample(32'd4, 1'b0);
        wait_drained();

        // fill to capacity, overflow, then restart on a full store
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        queue_sample(pick_sample(), 1'b1);
        for (int i = 1; i < CAPACITY + 3; i++)
            queue_sample(pick_sample(), 1'b0);
        queue_sample(pick_sample(), 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 68 : 0;
            recv_stall_pct = (ph == 2) ? 68 : ((ph == 3) ? 28 : 0);
            if (ph == 3) send_idle_pct = 28;
            for (int i = 0; i < 40; i++)
                queue_sample(pick_sample(), $urandom_range(0, 39) == 0);
            wait_drained();
        end

        drain = 0;
        while (drain < 400 && !out_valid)
        begin
            @(posedge clk);
            drain++;
        end
        if (fail_count == 0 && expected_medians.size() == 0 && !out_valid)
            $display("running_median_two_heaps_top_tb: PASS");
        else
            $display("running_median_two_heaps_top_tb: FAIL");
        $finish;
    end

endmodule
